[hdl/fct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;
  localparam int MAX_CELLS_DEF  = 4096;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SIZE_W = 13;
  localparam int IDX_W  = 12;
  localparam int OUT_W  = 32;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_DIMS   = 2'd3;

  // Input item functions.
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_XEDGE   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;     // capture the item and start the index setup
    logic       write;    // write all six memories at the latched index
    logic       fetch;    // issue one neighbour read, tap number below
    logic [2:0] tap;
    logic       acc;      // accumulate the data of the previous read
    logic [2:0] acc_tap;
    logic       finish;   // present the result
  } fct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_grid;
    logic xedge;
  } fct_stat_t;
endpackage
`default_nettype wire

[hdl/fct_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module fct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/fct_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module fct_ctrl import fct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      func,
  input  wire fct_stat_t stat,
  output logic           busy,
  output fct_cmd_t       cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] tap, tap_next;
  logic       is_read, is_read_next;

  assign busy = (state != S_IDLE);

  // Sequencer: index setup, then a write or six neighbour reads.
  always_comb begin
    state_next   = state;
    tap_next     = tap;
    is_read_next = is_read;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          is_read_next = func;
          state_next   = S_SETUP;
        end
      end
      S_SETUP: state_next = S_DEC;
      S_DEC: begin
        if (!is_read) begin
          cmd.write  = stat.in_grid;
          state_next = S_IDLE;
        end else if (!stat.in_grid || stat.xedge) begin
          state_next = S_DONE;
        end else begin
          tap_next   = 3'd0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch   = 1'b1;
        cmd.tap     = tap;
        cmd.acc     = (tap != 3'd0);
        cmd.acc_tap = tap - 3'd1;
        tap_next    = tap + 3'd1;
        if (tap == 3'd5) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.acc     = 1'b1;
        cmd.acc_tap = 3'd5;
        state_next  = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tap     <= '0;
      is_read <= 1'b0;
    end else begin
      state   <= state_next;
      tap     <= tap_next;
      is_read <= is_read_next;
    end
  end
endmodule
`default_nettype wire

[hdl/fct_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module fct_dp import fct_pkg::*; #(
  parameter int MAX_CELLS  = MAX_CELLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fct_cmd_t          cmd,
  output fct_stat_t              stat,
  input  wire logic [SIZE_W-1:0] size_x,
  input  wire logic [SIZE_W-1:0] size_y,
  input  wire logic [SIZE_W-1:0] size_z,
  input  wire logic              dims_mode,
  input  wire logic [IDX_W-1:0]  cell_index,
  input  wire logic [31:0]       in_fx_by,
  input  wire logic [31:0]       in_fx_bz,
  input  wire logic [31:0]       in_fy_bx,
  input  wire logic [31:0]       in_fy_bz,
  input  wire logic [31:0]       in_fz_bx,
  input  wire logic [31:0]       in_fz_by,
  output logic                   done,
  output logic [OUT_W-1:0]       out_fx_by,
  output logic [OUT_W-1:0]       out_fx_bz,
  output logic [OUT_W-1:0]       out_fy_bx,
  output logic [OUT_W-1:0]       out_fy_bz,
  output logic [OUT_W-1:0]       out_fz_bx,
  output logic [OUT_W-1:0]       out_fz_by,
  output logic [1:0]             status
);
  localparam int AW  = $clog2(MAX_CELLS);
  localparam int VB  = VALUE_BITS;
  // Sums of up to eight terms, with room for the factor two.
  localparam int SW  = VB + 4;
  localparam int PW  = 2 * SIZE_W;       // plane size
  localparam int NW  = 3 * SIZE_W;       // cell count
  localparam int EW  = NW + 2;           // address arithmetic, signed

  // Latched item.
  logic [IDX_W-1:0] idx;
  logic             dims;
  logic [VB-1:0]    wv [6];
  logic [PW-1:0]    plane;
  logic [NW-1:0]    ncell;
  logic             in_grid;
  logic             xedge;

  function automatic logic [VB-1:0] trunc(input logic [31:0] v);
    return VB'($signed(v));
  endfunction

  // Item capture with the plane size, then the cell count and the x edge bounds from the registered plane.
  // The x index boundary test uses x*plane compared against idx.
  logic [NW-1:0] lo_edge, hi_edge;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx   <= cell_index;
      dims  <= dims_mode;
      wv[0] <= trunc(in_fx_by);
      wv[1] <= trunc(in_fx_bz);
      wv[2] <= trunc(in_fy_bx);
      wv[3] <= trunc(in_fy_bz);
      wv[4] <= trunc(in_fz_bx);
      wv[5] <= trunc(in_fz_by);
      plane <= size_y * size_z;
    end
    ncell   <= NW'(size_x) * NW'(plane);
    lo_edge <= NW'(plane);
    hi_edge <= (NW'(size_x) - NW'(1)) * NW'(plane);
  end
  // x==0 iff idx<plane; x>=size_x-1 iff idx>=(size_x-1)*plane.
  assign in_grid = (NW'(idx) < ncell) && (32'(idx) < 32'(MAX_CELLS));
  assign xedge   = (NW'(idx) < lo_edge) || (NW'(idx) >= hi_edge);
  assign stat.in_grid = in_grid;
  assign stat.xedge   = xedge;

  // Six component memories: 0 fx_by 1 fx_bz 2 fy_bx 3 fy_bz 4 fz_bx 5 fz_by.
  logic [AW-1:0] raddr [6];
  logic [VB-1:0] rdata [6];
  logic          rvalid [6];
  logic          rvalid_q [6];

  genvar g;
  generate
    for (g = 0; g < 6; g++) begin : g_mem
      fct_ram #(.WIDTH(VB), .DEPTH(MAX_CELLS)) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (AW'(idx)),
        .wdata (wv[g]),
        .raddr (raddr[g]),
        .rdata (rdata[g])
      );
    end
  endgenerate

  // Strides.
  logic signed [EW-1:0] i_s, sx, sy, sz;
  assign i_s = EW'(idx);
  assign sx  = EW'(plane);
  assign sy  = EW'(size_z);
  assign sz  = EW'(1);

  // Each memory serves two stencils; per tap the address of each memory
  // covers its P role and its Q role:
  // P needs i, i+b, i-b; Q needs i, i+a, i-b, i+a-b.
  // Memory m plays P in stencil m and Q in its partner stencil.
  // Tap plan per memory (own stride Pb as P, Qa,Qb as Q):
  //  t0 i; t1 i+Pb; t2 i-Pb; t3 i+Qa; t4 i-Qb; t5 i+Qa-Qb.
  logic signed [EW-1:0] pb [6], qa [6], qb [6];
  always_comb begin
    // P stride (stencil where m is P), Q strides (partner where m is Q).
    pb[0] = sy; qa[0] = sy; qb[0] = sx; // fx_by
    pb[2] = sx; qa[2] = sx; qb[2] = sy; // fy_bx
    pb[3] = sz; qa[3] = sz; qb[3] = sy; // fy_bz
    pb[5] = sy; qa[5] = sy; qb[5] = sz; // fz_by
    pb[4] = sx; qa[4] = sx; qb[4] = sz; // fz_bx
    pb[1] = sz; qa[1] = sz; qb[1] = sx; // fx_bz
  end

  logic signed [EW-1:0] na [6];
  always_comb begin
    for (int m = 0; m < 6; m++) begin
      unique case (cmd.tap)
        3'd0: na[m] = i_s;
        3'd1: na[m] = i_s + pb[m];
        3'd2: na[m] = i_s - pb[m];
        3'd3: na[m] = i_s + qa[m];
        3'd4: na[m] = i_s - qb[m];
        3'd5: na[m] = i_s + qa[m] - qb[m];
        default: na[m] = i_s;
      endcase
      raddr[m]  = AW'(na[m]);
      rvalid[m] = (na[m] >= 0) && (na[m] < EW'(MAX_CELLS));
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < 6; m++) rvalid_q[m] <= rvalid[m];
  end

  // Fetched word with out-of-range neighbours read as zero.
  logic signed [VB-1:0] fw [6];
  always_comb begin
    for (int m = 0; m < 6; m++) fw[m] = rvalid_q[m] ? rdata[m] : '0;
  end

  // Stencil accumulators, one per output, indexed by P memory.
  logic signed [SW-1:0] acc [6];
  logic signed [VB-1:0] centre [6];
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int m = 0; m < 6; m++) acc[m] <= '0;
    end else if (cmd.acc) begin
      for (int m = 0; m < 6; m++) begin
        unique case (cmd.acc_tap)
          3'd0: begin
            acc[m]    <= acc[m] + (SW'(fw[m]) <<< 1);
            centre[m] <= fw[m];
          end
          3'd1, 3'd2: acc[m] <= acc[m] + SW'(fw[m]);
          default: acc[m] <= acc[m];
        endcase
      end
    end
  end

  // Q accumulators kept apart from the stencil accumulators, one per memory.
  logic signed [SW-1:0] qacc [6];
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int m = 0; m < 6; m++) qacc[m] <= '0;
    end else if (cmd.acc) begin
      for (int m = 0; m < 6; m++) begin
        if (cmd.acc_tap == 3'd0 || cmd.acc_tap == 3'd3 ||
            cmd.acc_tap == 3'd4 || cmd.acc_tap == 3'd5)
          qacc[m] <= qacc[m] + SW'(fw[m]);
      end
    end
  end

  // Floor division by eight and saturation to 32 bits.
  function automatic logic [OUT_W-1:0] fin(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] d;
    logic [OUT_W-1:0] r;
    d = s >>> 3;
    if (d > SW'(64'sh7FFFFFFF)) r = 32'h7FFFFFFF;
    else if (d < -SW'(64'sh80000000)) r = 32'h80000000;
    else r = d[OUT_W-1:0];
    return r;
  endfunction

  // Each stencil subtracts the Q sum of its partner memory.
  logic signed [SW-1:0] tot [6];
  always_comb begin
    tot[0] = acc[0] - qacc[2];
    tot[1] = acc[1] - qacc[4];
    tot[2] = acc[2] - qacc[0];
    tot[3] = acc[3] - qacc[5];
    tot[4] = acc[4] - qacc[1];
    tot[5] = acc[5] - qacc[3];
  end

  function automatic logic [OUT_W-1:0] ext(input logic signed [VB-1:0] v);
    return OUT_W'(SW'(v));
  endfunction

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.finish;
    if (cmd.finish) begin
      if (!in_grid || xedge) begin
        status    <= in_grid ? ST_XEDGE : ST_OUTSIDE;
        out_fx_by <= '0; out_fx_bz <= '0; out_fy_bx <= '0;
        out_fy_bz <= '0; out_fz_bx <= '0; out_fz_by <= '0;
      end else begin
        status    <= ST_OK;
        out_fx_by <= fin(tot[0]);
        out_fy_bx <= fin(tot[2]);
        if (dims) begin
          out_fx_bz <= fin(tot[1]);
          out_fy_bz <= fin(tot[3]);
          out_fz_bx <= fin(tot[4]);
          out_fz_by <= fin(tot[5]);
        end else begin
          out_fx_bz <= ext(centre[1]);
          out_fy_bz <= ext(centre[3]);
          out_fz_bx <= '0;
          out_fz_by <= '0;
        end
      end
    end
  end
endmodule
`default_nettype wire

[hdl/flux_ct_stencil.sv]
// A store item writes all six memories if its cell lies in the grid; a read item gives
// its result with done, early and with zero fluxes for an x-boundary or outside cell.
// One item at a time: start is taken only while idle. A read steps through six
// neighbour reads per memory, then the last accumulation and the result.
// Reset (rst, synchronous) restores the size registers to 16 and 3D mode;
// the cell memories are not cleared. The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none
module flux_ct_stencil import fct_pkg::*; #(
  parameter int MAX_CELLS  = MAX_CELLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire logic              func,
  input  wire logic [IDX_W-1:0]  cell_index,
  input  wire logic [31:0]       in_fx_by,
  input  wire logic [31:0]       in_fx_bz,
  input  wire logic [31:0]       in_fy_bx,
  input  wire logic [31:0]       in_fy_bz,
  input  wire logic [31:0]       in_fz_bx,
  input  wire logic [31:0]       in_fz_by,
  output logic                   done,
  output logic [OUT_W-1:0]       out_fx_by,
  output logic [OUT_W-1:0]       out_fx_bz,
  output logic [OUT_W-1:0]       out_fy_bx,
  output logic [OUT_W-1:0]       out_fy_bz,
  output logic [OUT_W-1:0]       out_fz_bx,
  output logic [OUT_W-1:0]       out_fz_by,
  output logic [1:0]             status
);
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic              dims_mode;
  fct_cmd_t          cmd;
  fct_stat_t         stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= SIZE_W'(16);
      size_y    <= SIZE_W'(16);
      size_z    <= SIZE_W'(16);
      dims_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x    <= cfg_data;
        REG_SIZE_Y: size_y    <= cfg_data;
        REG_SIZE_Z: size_z    <= cfg_data;
        REG_DIMS:   dims_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fct_ctrl u_ctrl (
    .clk (clk), .rst (rst), .start (start), .func (func),
    .stat (stat), .busy (busy), .cmd (cmd)
  );

  fct_dp #(.MAX_CELLS(MAX_CELLS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk (clk), .rst (rst), .cmd (cmd), .stat (stat),
    .size_x (size_x), .size_y (size_y), .size_z (size_z),
    .dims_mode (dims_mode), .cell_index (cell_index),
    .in_fx_by (in_fx_by), .in_fx_bz (in_fx_bz), .in_fy_bx (in_fy_bx),
    .in_fy_bz (in_fy_bz), .in_fz_bx (in_fz_bx), .in_fz_by (in_fz_by),
    .done (done),
    .out_fx_by (out_fx_by), .out_fx_bz (out_fx_bz), .out_fy_bx (out_fy_bx),
    .out_fy_bz (out_fy_bz), .out_fz_bx (out_fz_bx), .out_fz_by (out_fz_by),
    .status (status)
  );
endmodule
`default_nettype wire

[hdl/fct_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module fct_checker import fct_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status,
  input wire logic [31:0] out_fz_bx
);
  // An accepted item makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item not taken");
  // A result is a single-cycle strobe.
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");
  // Status never takes the unused code.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("bad status");
  // Non-ok results carry zero fluxes; the check looks at out_fz_bx only.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> out_fz_bx == '0) else $error("flux not zero");
endmodule

bind flux_ct_stencil fct_checker u_chk (
  .clk (clk), .rst (rst), .start (start), .busy (busy), .done (done),
  .status (status), .out_fz_bx (out_fz_bx)
);
`default_nettype wire
